// ===== rtl/crg_pkg.sv =====
// ============================================================================
// crg_pkg: shared constants and types for the chunked RMS gate
// Register indexes, register widths, reset values, item codes and the event
// bundle passed from the sequencer to the energy unit.
// ============================================================================
package crg_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;

   // Register field widths.
   localparam int FRAMES_W    = 10;
   localparam int CHANNELS_W  = 4;
   localparam int CUTOFF_W    = 15;
   localparam int CUTOFF_SQ_W = 2 * CUTOFF_W;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK_FRAMES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF_LEVEL  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GATE_MODE     = 2'd3;

   // Register reset values.
   localparam logic [FRAMES_W-1:0]   RST_CHUNK_FRAMES  = 10'd512;
   localparam logic [CHANNELS_W-1:0] RST_CHANNEL_COUNT = 4'd1;
   localparam logic [CUTOFF_W-1:0]   RST_CUTOFF_LEVEL  = 15'd3277;
   localparam logic                  RST_GATE_MODE     = 1'b0;

   // Request item modes.
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_FLUSH  = 1'b1;

   // Gate polarity codes.
   localparam logic GATE_QUIET = 1'b0;  // silence chunks below the cutoff
   localparam logic GATE_LOUD  = 1'b1;  // silence chunks above the cutoff

   // Per-item events from the sequencer to the energy unit.
   typedef struct packed {
      logic take_sample;   // a sample item was accepted this cycle
      logic close;         // the filling chunk closes with this item
   } crg_event_type;

endpackage

// ===== rtl/crg_if.sv =====
// ============================================================================
// crg_if: item channels of the chunked RMS gate
// Valid/ready channels for the request (sample or flush) and response items.
// ============================================================================
interface crg_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output mode, output sample_in, input ready);
   modport sink   (input valid, input mode, input sample_in, output ready);
endinterface

interface crg_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          last_out;

   modport source (output valid, output sample_out, output last_out, input ready);
   modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

// ===== rtl/chunk_rms_gate.sv =====
// ============================================================================
// chunk_rms_gate: chunked RMS noise gate
// Delays interleaved samples by one chunk and zeroes chunks whose energy
// falls on the gated side of cutoff^2 * chunk length.
// ============================================================================
// Usage:
//   req_chan carries items of mode and sample_in: mode 0 is a sample, mode 1
//   a flush tick at the end of a stream. rsp_chan carries sample_out and
//   last_out; last_out marks the final sample drained by a flush.
//   csr_we/csr_index/csr_wdata write chunk_frames, channel_count,
//   cutoff_level and gate_mode; write only while the block is idle.
//   Each sample item emits one sample of the previous chunk once a chunk has
//   closed; a flush closes a partial chunk and drains it one sample per tick.
//   Throughput is one item per cycle: each item uses the sample memory's
//   write port and read port once, and the energy sum takes one square per
//   cycle. Each result passes the read stage and the output register.
//   Reset clears counters and sums and restores the register defaults; the
//   sample memory needs no clearing pass. When the receiver stalls, the
//   output register and one read stage fill, then req_chan.ready drops.
// ============================================================================
module chunk_rms_gate #(
   parameter int MAX_CHUNK_SAMPLES = 4096,
   parameter int SAMPLE_BITS       = 16,
   parameter int MAX_CHANNELS      = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   crg_req_if.sink                         req_chan,
   crg_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [crg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [crg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import crg_pkg::*;

   localparam int CNT_W    = $clog2(MAX_CHUNK_SAMPLES + 1);
   localparam int IDX_W    = (MAX_CHUNK_SAMPLES > 1) ? $clog2(MAX_CHUNK_SAMPLES) : 1;
   localparam int DEPTH    = 2 * (2 ** IDX_W);
   localparam int SQ_W     = 2 * SAMPLE_BITS - 1;
   localparam int ENERGY_W = SQ_W + CNT_W - 1;
   localparam int LIMIT_W  = CUTOFF_SQ_W + CNT_W;

   logic [CNT_W-1:0]       chunk_len;
   logic [LIMIT_W-1:0]     energy_limit;
   logic                   gate_mode;
   logic                   silenced;
   crg_event_type          evt;
   logic                   wr_en;
   logic [IDX_W:0]         wr_addr;
   logic [SAMPLE_BITS-1:0] wr_data;
   logic                   rd_en;
   logic [IDX_W:0]         rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data;

   // Configuration registers and threshold.
   crg_cfg #(
      .MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES),
      .MAX_CHANNELS      (MAX_CHANNELS),
      .CNT_W             (CNT_W),
      .LIMIT_W           (LIMIT_W)
   ) u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .chunk_len    (chunk_len),
      .energy_limit (energy_limit),
      .gate_mode    (gate_mode)
   );

   // Energy accumulation and gate decision.
   crg_energy #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SQ_W        (SQ_W),
      .ENERGY_W    (ENERGY_W),
      .LIMIT_W     (LIMIT_W)
   ) u_energy (
      .clock        (clock),
      .reset        (reset),
      .evt          (evt),
      .sample       (req_chan.sample_in),
      .energy_limit (energy_limit),
      .gate_mode    (gate_mode),
      .silenced     (silenced)
   );

   // Fill/drain sequencing and output stage.
   crg_seq #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .IDX_W       (IDX_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .chunk_len (chunk_len),
      .silenced  (silenced),
      .evt       (evt),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // Two-bank sample memory: bank select is the top address bit.
   crg_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== rtl/crg_ram.sv =====
// ============================================================================
// crg_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ============================================================================
module crg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/crg_cfg.sv =====
// ============================================================================
// crg_cfg: configuration registers and energy threshold
// Holds the four registers, the saturated chunk length and the threshold
// cutoff^2 * length. Length and cutoff^2 are taken from the write data, so
// they are valid the cycle after a write; the threshold is registered from them.
// ============================================================================
module crg_cfg #(
   parameter int MAX_CHUNK_SAMPLES = 4096,
   parameter int MAX_CHANNELS      = 8,
   parameter int CNT_W             = 13,
   parameter int LIMIT_W           = 43
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [crg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [crg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [CNT_W-1:0]                   chunk_len,
   output logic [LIMIT_W-1:0]                 energy_limit,
   output logic                               gate_mode
);
   import crg_pkg::*;

   localparam int PROD_W = FRAMES_W + CHANNELS_W;

   // Samples per chunk: zero fields count as one, channels and length saturate.
   function automatic logic [CNT_W-1:0] calc_len(input logic [FRAMES_W-1:0] f,
                                                 input logic [CHANNELS_W-1:0] c);
      logic [FRAMES_W-1:0]   fv;
      logic [CHANNELS_W-1:0] cv;
      logic [PROD_W-1:0]     n;
      fv = (f == '0) ? FRAMES_W'(1) : f;
      cv = (c == '0) ? CHANNELS_W'(1) : c;
      if (int'(cv) > MAX_CHANNELS) begin
         cv = CHANNELS_W'(MAX_CHANNELS);
      end
      n = PROD_W'(fv) * PROD_W'(cv);
      if (int'(n) > MAX_CHUNK_SAMPLES) begin
         calc_len = CNT_W'(MAX_CHUNK_SAMPLES);
      end else begin
         calc_len = CNT_W'(n);
      end
   endfunction

   localparam logic [CNT_W-1:0]       RST_LEN       = calc_len(RST_CHUNK_FRAMES,
                                                               RST_CHANNEL_COUNT);
   localparam logic [CUTOFF_SQ_W-1:0] RST_CUTOFF_SQ = CUTOFF_SQ_W'(RST_CUTOFF_LEVEL) *
                                                      CUTOFF_SQ_W'(RST_CUTOFF_LEVEL);
   localparam logic [LIMIT_W-1:0]     RST_LIMIT     = LIMIT_W'(RST_CUTOFF_SQ) *
                                                      LIMIT_W'(RST_LEN);

   logic [FRAMES_W-1:0]    frames_ff,    frames_in;
   logic [CHANNELS_W-1:0]  channels_ff,  channels_in;
   logic [CUTOFF_W-1:0]    cutoff_ff,    cutoff_in;
   logic                   gate_ff,      gate_in;
   logic [CNT_W-1:0]       len_ff,       len_in;
   logic [CUTOFF_SQ_W-1:0] cutoff_sq_ff, cutoff_sq_in;
   logic [LIMIT_W-1:0]     limit_ff,     limit_in;

   // Register writes.
   always_comb begin
      frames_in   = frames_ff;
      channels_in = channels_ff;
      cutoff_in   = cutoff_ff;
      gate_in     = gate_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CHUNK_FRAMES:  frames_in   = csr_wdata[FRAMES_W-1:0];
            CSR_CHANNEL_COUNT: channels_in = csr_wdata[CHANNELS_W-1:0];
            CSR_CUTOFF_LEVEL:  cutoff_in   = csr_wdata[CUTOFF_W-1:0];
            CSR_GATE_MODE:     gate_in     = csr_wdata[0];
            default:           gate_in     = gate_ff;
         endcase
      end
   end

   // Derived values; the threshold product is one register behind its factors.
   always_comb begin
      len_in       = calc_len(frames_in, channels_in);
      cutoff_sq_in = CUTOFF_SQ_W'(cutoff_in) * CUTOFF_SQ_W'(cutoff_in);
      limit_in     = LIMIT_W'(cutoff_sq_ff) * LIMIT_W'(len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= RST_CHUNK_FRAMES;
         channels_ff  <= RST_CHANNEL_COUNT;
         cutoff_ff    <= RST_CUTOFF_LEVEL;
         gate_ff      <= RST_GATE_MODE;
         len_ff       <= RST_LEN;
         cutoff_sq_ff <= RST_CUTOFF_SQ;
         limit_ff     <= RST_LIMIT;
      end else begin
         frames_ff    <= frames_in;
         channels_ff  <= channels_in;
         cutoff_ff    <= cutoff_in;
         gate_ff      <= gate_in;
         len_ff       <= len_in;
         cutoff_sq_ff <= cutoff_sq_in;
         limit_ff     <= limit_in;
      end
   end

   assign chunk_len    = len_ff;
   assign energy_limit = limit_ff;
   assign gate_mode    = gate_ff;

endmodule

// ===== rtl/crg_energy.sv =====
// ============================================================================
// crg_energy: sum of squares and gate decision
// Squares each accepted sample into a register and folds it into the sum on
// the next cycle. The cycle after a chunk closes, its total is compared with
// the threshold and the gate flag for the draining chunk is updated.
// ============================================================================
module crg_energy #(
   parameter int SAMPLE_BITS = 16,
   parameter int SQ_W        = 31,
   parameter int ENERGY_W    = 43,
   parameter int LIMIT_W     = 43
) (
   input  logic                          clock,
   input  logic                          reset,
   input  crg_pkg::crg_event_type        evt,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [LIMIT_W-1:0]            energy_limit,
   input  logic                          gate_mode,
   output logic                          silenced
);
   import crg_pkg::*;

   localparam int CMP_W = (ENERGY_W > LIMIT_W) ? ENERGY_W : LIMIT_W;

   logic signed [2*SAMPLE_BITS-1:0] square;
   logic [SQ_W-1:0]                 sq_ff,       sq_in;
   logic [ENERGY_W-1:0]             energy_ff,   energy_in;
   logic                            pend_ff,     pend_in;
   logic                            silenced_ff, silenced_in;
   logic [ENERGY_W-1:0]             total;
   logic [CMP_W-1:0]                total_x;
   logic [CMP_W-1:0]                limit_x;
   logic                            gated;

   // Square of the incoming sample; it is never negative.
   always_comb begin
      square = sample * sample;
      sq_in  = evt.take_sample ? square[SQ_W-1:0] : '0;
   end

   // Running total of the chunk that the pending square belongs to.
   always_comb begin
      total     = energy_ff + ENERGY_W'(sq_ff);
      energy_in = pend_ff ? '0 : total;
      pend_in   = evt.close;
   end

   // Gate decision for a chunk that closed on the previous cycle.
   always_comb begin
      total_x     = CMP_W'(total);
      limit_x     = CMP_W'(energy_limit);
      gated       = (gate_mode == GATE_LOUD) ? (total_x > limit_x) : (total_x < limit_x);
      silenced_in = pend_ff ? gated : silenced_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff       <= '0;
         energy_ff   <= '0;
         pend_ff     <= 1'b0;
         silenced_ff <= 1'b0;
      end else begin
         sq_ff       <= sq_in;
         energy_ff   <= energy_in;
         pend_ff     <= pend_in;
         silenced_ff <= silenced_in;
      end
   end

   assign silenced = silenced_in;

endmodule

// ===== rtl/crg_seq.sv =====
// ============================================================================
// crg_seq: fill/drain sequencer and output stage
// Tracks the fill and drain positions in the two-bank sample memory, issues
// at most one write and at most one read per item, and carries read data
// through a one-entry stage into the output register.
// ============================================================================
module crg_seq #(
   parameter int SAMPLE_BITS = 16,
   parameter int CNT_W       = 13,
   parameter int IDX_W       = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   crg_req_if.sink                req_chan,
   crg_rsp_if.source              rsp_chan,
   input  logic [CNT_W-1:0]       chunk_len,
   input  logic                   silenced,
   output crg_pkg::crg_event_type evt,
   output logic                   wr_en,
   output logic [IDX_W:0]         wr_addr,
   output logic [SAMPLE_BITS-1:0] wr_data,
   output logic                   rd_en,
   output logic [IDX_W:0]         rd_addr,
   input  logic [SAMPLE_BITS-1:0] rd_data
);
   import crg_pkg::*;

   logic [CNT_W-1:0]       fill_count_ff,   fill_count_in;
   logic [CNT_W-1:0]       drain_count_ff,  drain_count_in;
   logic [CNT_W-1:0]       drain_length_ff, drain_length_in;
   logic                   fill_bank_ff,    fill_bank_in;
   logic                   s1_valid_ff,     s1_valid_in;
   logic                   s1_last_ff,      s1_last_in;
   logic                   s1_sil_ff,       s1_sil_in;
   logic                   s1_use_pend_ff,  s1_use_pend_in;
   logic                   out_valid_ff,    out_valid_in;
   logic [SAMPLE_BITS-1:0] out_sample_ff,   out_sample_in;
   logic                   out_last_ff,     out_last_in;

   logic             accept;
   logic             take_sample;
   logic             take_flush;
   logic             drain_pend;
   logic [CNT_W:0]   fill_inc;
   logic             sample_close;
   logic             flush_close;
   logic             emit;
   logic [CNT_W-1:0] drain_idx;
   logic             drain_bank;
   logic [CNT_W-1:0] len_eff;
   logic [CNT_W-1:0] fill_after;
   logic [CNT_W:0]   idx_inc;
   logic             last;
   logic             advance;
   logic             out_load;
   logic             gate;

   // Handshake: a new item enters whenever the read stage can move on.
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign take_sample    = accept && (req_chan.mode == MODE_SAMPLE);
   assign take_flush     = accept && (req_chan.mode == MODE_FLUSH);

   // Chunk closing and drain selection for the accepted item.
   always_comb begin
      drain_pend   = drain_count_ff < drain_length_ff;
      fill_inc     = {1'b0, fill_count_ff} + 1'b1;
      sample_close = take_sample && (fill_inc >= {1'b0, chunk_len});
      flush_close  = take_flush && !drain_pend && (fill_count_ff != '0);
      emit         = (take_sample && drain_pend) ||
                     (take_flush && (drain_pend || flush_close));
      drain_idx    = flush_close ? '0 : drain_count_ff;
      drain_bank   = flush_close ? fill_bank_ff : !fill_bank_ff;
      len_eff      = flush_close ? fill_count_ff : drain_length_ff;
      fill_after   = flush_close ? '0 : fill_count_ff;
      idx_inc      = {1'b0, drain_idx} + 1'b1;
      last         = take_flush && (idx_inc >= {1'b0, len_eff}) && (fill_after == '0);
   end

   // Counter and bank updates.
   always_comb begin
      fill_count_in   = fill_count_ff;
      drain_count_in  = drain_count_ff;
      drain_length_in = drain_length_ff;
      fill_bank_in    = fill_bank_ff;
      if (emit) begin
         drain_count_in = idx_inc[CNT_W-1:0];
      end
      if (take_sample) begin
         fill_count_in = fill_inc[CNT_W-1:0];
      end
      if (sample_close) begin
         drain_length_in = fill_inc[CNT_W-1:0];
         drain_count_in  = '0;
         fill_bank_in    = !fill_bank_ff;
         fill_count_in   = '0;
      end
      if (flush_close) begin
         drain_length_in = fill_count_ff;
         fill_bank_in    = !fill_bank_ff;
         fill_count_in   = '0;
      end
   end

   // Memory accesses: the fill and drain banks differ, but for a flush that drains the chunk it closes.
   assign wr_en   = take_sample;
   assign wr_addr = {fill_bank_ff, fill_count_ff[IDX_W-1:0]};
   assign wr_data = req_chan.sample_in;
   assign rd_en   = emit;
   assign rd_addr = {drain_bank, drain_idx[IDX_W-1:0]};

   assign evt.take_sample = take_sample;
   assign evt.close       = sample_close || flush_close;

   // Read stage: holds the item whose memory data is on rd_data.
   always_comb begin
      s1_valid_in    = emit ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_last_in     = emit ? last : s1_last_ff;
      s1_sil_in      = emit ? silenced : s1_sil_ff;
      s1_use_pend_in = emit ? flush_close : s1_use_pend_ff;
   end

   // Output register; a chunk closed by a flush takes its gate decision from the energy unit when it loads.
   always_comb begin
      out_load      = s1_valid_ff && advance;
      gate          = s1_use_pend_ff ? silenced : s1_sil_ff;
      out_valid_in  = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      out_sample_in = out_load ? (gate ? '0 : rd_data) : out_sample_ff;
      out_last_in   = out_load ? s1_last_ff : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff   <= '0;
         drain_count_ff  <= '0;
         drain_length_ff <= '0;
         fill_bank_ff    <= 1'b0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         fill_count_ff   <= fill_count_in;
         drain_count_ff  <= drain_count_in;
         drain_length_ff <= drain_length_in;
         fill_bank_ff    <= fill_bank_in;
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff     <= s1_last_in;
      s1_sil_ff      <= s1_sil_in;
      s1_use_pend_ff <= s1_use_pend_in;
      out_sample_ff  <= out_sample_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.sample_out = out_sample_ff;
   assign rsp_chan.last_out   = out_last_ff;

endmodule

// ===== rtl/crg_checker.sv =====
// ============================================================================
// crg_checker: port-level checks for the chunked RMS gate
// Watches the item channels of the top level and is bound to it below.
// ============================================================================
module crg_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_sample,
   input logic                   rsp_last
);

   // A stalled result keeps its item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_last))
      else $error("result item changed while stalled");

   // Reset empties the output.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A fresh result always comes from an accepted item that passed the read stage and the output register.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result item without a matching input item");

   // The input side is open whenever the output side can move.
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled while the output was free");

endmodule

bind chunk_rms_gate crg_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sample (rsp_chan.sample_out),
   .rsp_last   (rsp_chan.last_out)
);
